// ----- rtl/c8ic_pkg.sv -----
// Package for the CHIP-8 instruction cycle core: function codes, sequencer states,
// opcode groups and the hex font table. No dependencies.
`default_nettype none
package c8ic_pkg;

    localparam int unsigned AddrW   = 12;
    localparam int unsigned FontLen = 80;
    localparam logic [11:0] PcStart = 12'h200;

    typedef enum logic [1:0] {
        FN_LOAD = 2'd0,
        FN_EXEC = 2'd1,
        FN_ROW  = 2'd2,
        FN_NOP  = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        GRP_CALL = 4'h2,
        GRP_ALU  = 4'h8,
        GRP_LDI  = 4'hA,
        GRP_DRAW = 4'hD,
        GRP_MISC = 4'hF
    } t_grp;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH_HI,
        ST_FETCH_LO,
        ST_DECODE,
        ST_BCD,
        ST_SPR_RD,
        ST_SPR_WR,
        ST_ROW_RD,
        ST_OUT
    } t_state;

    // last member sits in the lowest bits: status is bit 0
    typedef struct packed {
        logic [63:0] row_pixels;
        logic        draw_pending;
        logic [7:0]  flag_reg;
        logic [15:0] fetched_opcode;
        logic [11:0] pc_now;
        logic        status;
    } t_result;

    function automatic logic [7:0] font_byte(input logic [6:0] idx);
        logic [7:0] b;
        case (idx)
            7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd22, 7'd25,
            7'd27, 7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40, 7'd42, 7'd44, 7'd45,
            7'd47, 7'd49, 7'd50, 7'd52, 7'd60, 7'd64, 7'd70, 7'd72, 7'd74, 7'd75,
            7'd77: b = 8'hF0;
            7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46, 7'd51,
            7'd53, 7'd54, 7'd56, 7'd58, 7'd66, 7'd67, 7'd68: b = 8'h90;
            7'd5, 7'd7, 7'd8, 7'd37: b = 8'h20;
            7'd6: b = 8'h60;
            7'd9: b = 8'h70;
            7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48: b = 8'h10;
            7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73, 7'd76, 7'd78,
            7'd79: b = 8'h80;
            7'd38, 7'd39: b = 8'h40;
            7'd55, 7'd57, 7'd59, 7'd65, 7'd69: b = 8'hE0;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/c8ic_mem.sv -----
// Main memory of the CHIP-8 core: 4096 bytes, one write and one registered read per cycle.
// Depends on c8ic_pkg for the address width.
`default_nettype none
module c8ic_mem (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [c8ic_pkg::AddrW-1:0] i_waddr,
    input  wire logic [7:0]                i_wdata,
    input  wire logic [c8ic_pkg::AddrW-1:0] i_raddr,
    output logic      [7:0]                o_rdata
);
    logic [7:0] r_mem [0:(1 << c8ic_pkg::AddrW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/c8ic_disp.sv -----
// Display memory of the CHIP-8 core: 32 rows of 64 pixels, one write and one
// registered read per cycle. Depends on nothing.
`default_nettype none
module c8ic_disp (
    input  wire logic        i_clk,
    input  wire logic        i_we,
    input  wire logic [4:0]  i_waddr,
    input  wire logic [63:0] i_wdata,
    input  wire logic [4:0]  i_raddr,
    output logic      [63:0] o_rdata
);
    logic [63:0] r_rows [0:31];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_rows[i_waddr] <= i_wdata;
        end
        o_rdata <= r_rows[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/chip8_instruction_cycle_core.sv -----
// CHIP-8 instruction cycle core: sequencer around main memory and display memory.
// DXYN passes through ST_SPR_RD and ST_SPR_WR for each drawn row; one request in flight at
// a time, the next taken only after the result has been accepted on the output.
// Reset: a clearing pass writes the font and zeros into all 4096 bytes of main memory
// and clears the 32 display rows; no request is taken until it ends.
// Depends on c8ic_pkg, c8ic_mem and c8ic_disp.
`default_nettype none
module chip8_instruction_cycle_core #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // func[1:0], load_addr[13:2], load_byte[21:14], row_select[26:22], zero pad
    input  wire logic [31:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[0], pc_now[12:1], fetched_opcode[28:13], flag_reg[36:29],
    // draw_pending[37], row_pixels[101:38], zero pad
    output logic [103:0]      m_axis_tdata
);
    localparam int unsigned SpW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    c8ic_pkg::t_state r_state, n_state;
    logic [11:0] r_clr, n_clr;
    logic [7:0]  r_v [0:15];
    logic [11:0] r_i, r_pc;
    logic [SpW-1:0] r_sp;
    logic [11:0] r_stack [0:STACK_DEPTH-1];
    logic        r_draw;
    logic [15:0] r_op;
    logic [1:0]  r_func;
    logic [3:0]  r_n, r_cnt;
    logic        r_hit, r_status;
    logic [5:0]  r_x0;
    logic [4:0]  r_y0;
    logic [1:0]  r_bcd;
    logic [63:0] r_row;
    logic [7:0]  r_spr;
    logic        r_ovalid;
    c8ic_pkg::t_result r_res;

    logic        mem_we;
    logic [11:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd, mem_rd;
    logic        disp_we;
    logic [4:0]  disp_wa, disp_ra;
    logic [63:0] disp_wd, disp_rd;

    c8ic_mem u_mem (.i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_wa), .i_wdata(mem_wd),
                    .i_raddr(mem_ra), .o_rdata(mem_rd));
    c8ic_disp u_disp (.i_clk(i_clk), .i_we(disp_we), .i_waddr(disp_wa), .i_wdata(disp_wd),
                      .i_raddr(disp_ra), .o_rdata(disp_rd));

    logic        accept;
    logic [3:0]  x_idx, y_idx;
    logic [7:0]  vx;
    logic [8:0]  alu_sum;
    logic [4:0]  ycur;
    logic [63:0] spr_bits;
    logic [127:0] spr_wide;
    logic [7:0]  hund, tens, ones;
    logic [7:0]  tmp;

    assign s_axis_tready = (r_state == c8ic_pkg::ST_IDLE) && !r_ovalid;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {2'b00, r_res};
    assign x_idx = r_op[11:8];
    // low opcode byte sits on the read port during decode
    assign y_idx = mem_rd[7:4];
    assign vx = r_v[x_idx];
    assign alu_sum = {1'b0, vx} + {1'b0, r_v[y_idx]};
    assign ycur = r_y0 + 5'(r_cnt);
    assign spr_wide = {r_spr, 120'd0} >> r_x0;
    assign spr_bits = spr_wide[127:64];

    // BCD digits: hundreds by small constant compares, tens by multiply-and-shift
    always_comb begin
        hund = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
        tmp  = vx - 8'(hund * 8'd100);
        tens = 8'(({8'd0, tmp} * 16'd205) >> 11);
        ones = tmp - 8'(tens * 8'd10);
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        mem_we  = 1'b0;
        mem_wa  = r_clr;
        mem_wd  = 8'd0;
        mem_ra  = r_pc;
        disp_we = 1'b0;
        disp_wa = ycur;
        disp_wd = r_row ^ spr_bits;
        disp_ra = ycur;
        case (r_state)
            c8ic_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wd = (r_clr < 12'(c8ic_pkg::FontLen)) ?
                         c8ic_pkg::font_byte(r_clr[6:0]) : 8'd0;
                disp_we = (r_clr < 12'd32);
                disp_wa = r_clr[4:0];
                disp_wd = 64'd0;
                n_clr = r_clr + 12'd1;
                if (r_clr == 12'hFFF) begin
                    n_state = c8ic_pkg::ST_IDLE;
                end
            end
            c8ic_pkg::ST_IDLE: begin
                if (accept) begin
                    case (c8ic_pkg::t_func'(s_axis_tdata[1:0]))
                        c8ic_pkg::FN_LOAD: begin
                            mem_we = 1'b1;
                            mem_wa = s_axis_tdata[13:2];
                            mem_wd = s_axis_tdata[21:14];
                            n_state = c8ic_pkg::ST_OUT;
                        end
                        c8ic_pkg::FN_EXEC: n_state = c8ic_pkg::ST_FETCH_HI;
                        c8ic_pkg::FN_ROW: begin
                            disp_ra = s_axis_tdata[26:22];
                            n_state = c8ic_pkg::ST_ROW_RD;
                        end
                        default: n_state = c8ic_pkg::ST_OUT;
                    endcase
                end
            end
            c8ic_pkg::ST_FETCH_HI: begin
                mem_ra = r_pc + 12'd1;
                n_state = c8ic_pkg::ST_FETCH_LO;
            end
            c8ic_pkg::ST_FETCH_LO: begin
                // hold the low byte on the read port through decode
                mem_ra = r_pc + 12'd1;
                n_state = c8ic_pkg::ST_DECODE;
            end
            c8ic_pkg::ST_DECODE: begin
                n_state = c8ic_pkg::ST_OUT;
                if (r_op[15:12] == c8ic_pkg::GRP_MISC && mem_rd == 8'h33) begin
                    n_state = c8ic_pkg::ST_BCD;
                end else if (r_op[15:12] == c8ic_pkg::GRP_DRAW && mem_rd[3:0] != 4'd0) begin
                    mem_ra = r_i;
                    disp_ra = r_v[y_idx][4:0];
                    n_state = c8ic_pkg::ST_SPR_RD;
                end
            end
            c8ic_pkg::ST_BCD: begin
                mem_we = 1'b1;
                mem_wa = r_i + 12'(r_bcd);
                mem_wd = (r_bcd == 2'd0) ? hund : (r_bcd == 2'd1) ? tens : ones;
                if (r_bcd == 2'd2) begin
                    n_state = c8ic_pkg::ST_OUT;
                end
            end
            c8ic_pkg::ST_SPR_RD: n_state = c8ic_pkg::ST_SPR_WR;
            c8ic_pkg::ST_SPR_WR: begin
                disp_we = 1'b1;
                mem_ra = r_i + 12'(r_cnt) + 12'd1;
                disp_ra = ycur + 5'd1;
                if (r_cnt + 4'd1 == r_n || {1'b0, ycur} + 6'd1 >= 6'd32) begin
                    n_state = c8ic_pkg::ST_OUT;
                end else begin
                    n_state = c8ic_pkg::ST_SPR_RD;
                end
            end
            c8ic_pkg::ST_ROW_RD: n_state = c8ic_pkg::ST_OUT;
            c8ic_pkg::ST_OUT: n_state = c8ic_pkg::ST_IDLE;
            default: n_state = c8ic_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= c8ic_pkg::ST_CLEAR;
            r_clr    <= 12'd0;
            r_i      <= 12'd0;
            r_pc     <= c8ic_pkg::PcStart;
            r_sp     <= '0;
            r_draw   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 16; k++) begin
                r_v[k] <= 8'd0;
            end
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                c8ic_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_func   <= s_axis_tdata[1:0];
                        r_op     <= 16'd0;
                        r_status <= 1'b0;
                        r_row    <= 64'd0;
                    end
                end
                c8ic_pkg::ST_FETCH_HI: r_op[15:8] <= mem_rd;
                c8ic_pkg::ST_DECODE: begin
                    r_op[7:0] <= mem_rd;
                end
                c8ic_pkg::ST_BCD: r_bcd <= r_bcd + 2'd1;
                c8ic_pkg::ST_SPR_RD: begin
                    r_spr <= mem_rd;
                    r_row <= disp_rd;
                end
                c8ic_pkg::ST_SPR_WR: begin
                    if ((r_row & spr_bits) != 64'd0) begin
                        r_hit <= 1'b1;
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (n_state == c8ic_pkg::ST_OUT) begin
                        r_v[15] <= {7'd0, r_hit | ((r_row & spr_bits) != 64'd0)};
                    end
                end
                c8ic_pkg::ST_ROW_RD: r_row <= disp_rd;
                default: ;
            endcase
            if (r_state == c8ic_pkg::ST_DECODE) begin
                r_bcd <= 2'd0;
                r_cnt <= 4'd0;
                r_hit <= 1'b0;
                r_x0  <= vx[5:0];
                r_y0  <= r_v[y_idx][4:0];
                r_n   <= mem_rd[3:0];
            end
            if (r_state == c8ic_pkg::ST_OUT) begin
                r_ovalid <= 1'b1;
                r_res.status         <= r_status;
                r_res.pc_now         <= r_pc;
                r_res.fetched_opcode <= r_op;
                r_res.flag_reg       <= r_v[15];
                r_res.draw_pending   <= r_draw;
                r_res.row_pixels     <= (r_func == c8ic_pkg::FN_ROW) ? r_row : 64'd0;
            end
            // execute once the whole opcode word is known
            if (r_state == c8ic_pkg::ST_DECODE) begin
                case (c8ic_pkg::t_grp'(r_op[15:12]))
                    c8ic_pkg::GRP_CALL: begin
                        r_stack[r_sp] <= r_pc + 12'd2;
                        r_sp <= (32'(r_sp) + 1 >= STACK_DEPTH) ? '0 : r_sp + SpW'(1);
                        r_pc <= {r_op[11:8], mem_rd};
                    end
                    c8ic_pkg::GRP_ALU: begin
                        if (mem_rd[3:0] == 4'd4) begin
                            // carry wins when the target is VF
                            if (x_idx != 4'hF) begin
                                r_v[x_idx] <= alu_sum[7:0];
                            end
                            r_v[15] <= {7'd0, alu_sum[8]};
                            r_pc <= r_pc + 12'd2;
                        end else begin
                            r_status <= 1'b1;
                        end
                    end
                    c8ic_pkg::GRP_LDI: begin
                        r_i <= {r_op[11:8], mem_rd};
                        r_pc <= r_pc + 12'd2;
                    end
                    c8ic_pkg::GRP_DRAW: begin
                        r_draw <= 1'b1;
                        r_pc <= r_pc + 12'd2;
                        if (mem_rd[3:0] == 4'd0) begin
                            r_v[15] <= 8'd0;
                        end
                    end
                    c8ic_pkg::GRP_MISC: begin
                        if (mem_rd == 8'h33) begin
                            r_pc <= r_pc + 12'd2;
                        end else begin
                            r_status <= 1'b1;
                        end
                    end
                    default: r_status <= 1'b1;
                endcase
            end
        end
    end

endmodule
`default_nettype wire
